/* hw/rtl/fixed_latency_memory_line_engine_unit_assert.svh */
// Assertion macros shared by the memory line engine RTL.
// Needs nothing else; the bodies are empty when SYNTHESIS is defined.
`ifndef FIXED_LATENCY_MEMORY_LINE_ENGINE_UNIT_ASSERT_SVH
`define FIXED_LATENCY_MEMORY_LINE_ENGINE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define FLMLE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("flmle assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define FLMLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("flmle assertion failed");
`else
`define FLMLE_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define FLMLE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* hw/rtl/flmle_pkg.sv */
// Types and constants of the memory line engine.
// Used by the controller, the datapath and the top level; depends on nothing.
package flmle_pkg;

    localparam int LINE_BYTES = 8;
    localparam int IN_TDATA_W = 112;
    localparam int OUT_TDATA_W = 88;

    localparam logic [2:0] K_TICK  = 3'd0;
    localparam logic [2:0] K_IDLE  = 3'd0;
    localparam logic [2:0] K_FETCH = 3'd1;
    localparam logic [2:0] K_STORE = 3'd2;
    localparam logic [2:0] K_FILL  = 3'd3;
    localparam logic [2:0] K_FLUSH = 3'd4;
    localparam logic [2:0] K_MOVE  = 3'd5;

    localparam logic [1:0] ST_INVALID = 2'd0;
    localparam logic [1:0] ST_VALID   = 2'd1;
    localparam logic [1:0] ST_UPDATED = 2'd2;

    localparam logic [2:0] LAST_IDX = 3'(LINE_BYTES - 1);

    // Packed so that func lands in the lowest bits.
    typedef struct packed {
        logic [6:0]  pad;
        logic [15:0] byte_states;
        logic [63:0] line_data;
        logic [4:0]  old_line_index;
        logic [4:0]  line_index;
        logic [3:0]  byte_count;
        logic [7:0]  byte_address;
        logic [2:0]  func;
    } t_in_item;

    typedef struct packed {
        logic [4:0]  pad;
        logic [15:0] new_states;
        logic [63:0] read_data;
        logic [2:0]  done_kind;
    } t_out_item;

    typedef struct packed {
        logic       take;
        logic       wr_en;
        logic       rd_en;
        logic       load_out;
        logic [2:0] idx;
    } t_cmd;

    typedef struct packed {
        logic fire;
        logic has_write;
        logic has_read;
        logic out_free;
    } t_status;

endpackage

/* hw/rtl/flmle_ctrl.sv */
// Controller of the memory line engine: sequences the byte write and read phases.
// Depends on flmle_pkg and the assertion macro header.
`include "fixed_latency_memory_line_engine_unit_assert.svh"

module flmle_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  flmle_pkg::t_status i_status,
    output flmle_pkg::t_cmd    o_cmd
);
    import flmle_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRITE,
        S_READ,
        S_LAST,
        S_OUT
    } t_state;

    t_state     r_state;
    logic [2:0] r_idx;
    logic       take;

    assign o_ready = (r_state == S_IDLE);
    assign take = i_valid && o_ready;

    always_comb begin
        o_cmd.take = take;
        o_cmd.wr_en = (r_state == S_WRITE);
        o_cmd.rd_en = (r_state == S_READ);
        o_cmd.load_out = (r_state == S_OUT) && i_status.out_free;
        o_cmd.idx = r_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx <= 3'd0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_idx <= 3'd0;
                    if (take && i_status.fire) begin
                        r_state <= i_status.has_write ? S_WRITE : S_READ;
                    end
                end
                S_WRITE: begin
                    if (r_idx == LAST_IDX) begin
                        r_idx <= 3'd0;
                        r_state <= i_status.has_read ? S_READ : S_OUT;
                    end else begin
                        r_idx <= r_idx + 3'd1;
                    end
                end
                S_READ: begin
                    if (r_idx == LAST_IDX) begin
                        r_idx <= 3'd0;
                        r_state <= S_LAST;
                    end else begin
                        r_idx <= r_idx + 3'd1;
                    end
                end
                // The last read byte is collected here.
                S_LAST: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_status.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `FLMLE_ASSERT_NOW(a_one_command, i_clk, i_rst_n, 1'b1, $onehot0({o_cmd.wr_en, o_cmd.rd_en, o_cmd.load_out}))
    `FLMLE_ASSERT_NEXT(a_fire_goes_busy, i_clk, i_rst_n, take && i_status.fire, !o_ready)
    `FLMLE_ASSERT_NEXT(a_load_returns_idle, i_clk, i_rst_n, o_cmd.load_out, o_ready)

endmodule

/* hw/rtl/flmle_dp.sv */
// Datapath of the memory line engine: pending request, byte memory, result register.
// Depends on flmle_pkg and the assertion macro header.
`include "fixed_latency_memory_line_engine_unit_assert.svh"

module flmle_dp #(
    parameter int MEM_BYTES = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  flmle_pkg::t_in_item  i_item,
    input  logic [3:0]           i_latency,
    input  flmle_pkg::t_cmd      i_cmd,
    output flmle_pkg::t_status   o_status,
    output flmle_pkg::t_out_item o_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready
);
    import flmle_pkg::*;

    localparam int AW = $clog2(MEM_BYTES);
    localparam logic [9:0] MEM_SIZE = 10'(MEM_BYTES);
    localparam logic [9:0] MEM_TWICE = 10'(2 * MEM_BYTES);

    // Pending request.
    logic [2:0]  r_kind;
    logic [3:0]  r_tick;
    logic [7:0]  r_addr;
    logic [4:0]  r_old_line;
    logic [3:0]  r_count;
    logic [63:0] r_data;
    logic [15:0] r_states;

    // Byte memory; a byte never written reads as zero through its valid bit.
    logic [7:0]  r_mem [MEM_BYTES];
    logic        r_vld [MEM_BYTES];
    logic [7:0]  r_rdata;
    logic        r_rvld;
    logic        r_rd_pend;
    logic [2:0]  r_rd_idx;
    logic [7:0][7:0] r_rbytes;

    // Result register.
    logic        r_out_valid;
    t_out_item   r_out;

    logic [3:0]  lat;
    logic [7:0]  rd_addr;
    logic [7:0]  wr_addr;
    logic [7:0]  obase;
    logic [AW-1:0] rd_slot;
    logic [AW-1:0] wr_slot;
    logic [1:0]  wr_state;
    logic        wr_keep;
    logic [7:0]  wr_byte;
    logic [63:0] n_out_data;
    logic [15:0] n_out_states;
    logic [3:0]  n_cnt;

    // Address below four times the depth, so two conditional subtractions suffice.
    function automatic logic [AW-1:0] mem_slot(input logic [7:0] a);
        logic [9:0] v;
        v = {2'b00, a};
        if (v >= MEM_TWICE) v = v - MEM_TWICE;
        if (v >= MEM_SIZE) v = v - MEM_SIZE;
        return v[AW-1:0];
    endfunction

    assign lat = (i_latency == 4'd0) ? 4'd1 : i_latency;

    always_comb begin
        o_status.fire = (i_item.func == K_TICK) && (r_kind != K_IDLE) &&
                        (({1'b0, r_tick} + 5'd1) >= {1'b0, lat});
        o_status.has_write = (r_kind == K_STORE) || (r_kind == K_FLUSH) ||
                             (r_kind == K_MOVE);
        o_status.has_read = (r_kind == K_FETCH) || (r_kind == K_FILL) ||
                            (r_kind == K_MOVE);
        o_status.out_free = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= K_IDLE;
            r_tick <= 4'd0;
            r_addr <= 8'd0;
            r_old_line <= 5'd0;
            r_count <= 4'd1;
            r_data <= 64'd0;
            r_states <= 16'd0;
        end else begin
            if (i_cmd.take) begin
                if (i_item.func >= K_FETCH && i_item.func <= K_MOVE) begin
                    r_kind <= i_item.func;
                    if (i_item.func == K_FETCH || i_item.func == K_STORE) begin
                        r_addr <= i_item.byte_address;
                    end else begin
                        r_addr <= {i_item.line_index, 3'b000};
                    end
                    r_count <= i_item.byte_count;
                    r_old_line <= i_item.old_line_index;
                    r_data <= i_item.line_data;
                    r_states <= i_item.byte_states;
                end else if (i_item.func == K_TICK && r_kind != K_IDLE) begin
                    r_tick <= o_status.fire ? 4'd0 : r_tick + 4'd1;
                end
            end
            if (i_cmd.load_out) begin
                r_kind <= K_IDLE;
            end
        end
    end

    assign obase = {r_old_line, 3'b000};
    assign rd_addr = r_addr + {5'd0, i_cmd.idx};
    assign wr_addr = ((r_kind == K_MOVE) ? obase : r_addr) + {5'd0, i_cmd.idx};
    assign rd_slot = mem_slot(rd_addr);
    assign wr_slot = mem_slot(wr_addr);
    assign wr_state = r_states[{i_cmd.idx, 1'b0} +: 2];
    assign wr_byte = r_data[{i_cmd.idx, 3'b000} +: 8];

    always_comb begin
        case (r_kind)
            K_STORE: wr_keep = (i_cmd.idx == 3'd0);
            K_FLUSH: wr_keep = (wr_state == ST_UPDATED);
            K_MOVE:  wr_keep = (wr_state != ST_INVALID);
            default: wr_keep = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en && wr_keep) begin
            r_mem[wr_slot] <= wr_byte;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[rd_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MEM_BYTES; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_cmd.wr_en && wr_keep) begin
            r_vld[wr_slot] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_pend <= 1'b0;
        end else begin
            r_rd_pend <= i_cmd.rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rvld <= r_vld[rd_slot];
            r_rd_idx <= i_cmd.idx;
        end
        if (r_rd_pend) begin
            r_rbytes[r_rd_idx] <= r_rvld ? r_rdata : 8'd0;
        end
    end

    assign n_cnt = (r_count > 4'(LINE_BYTES)) ? 4'(LINE_BYTES) : r_count;

    always_comb begin
        n_out_data = 64'd0;
        n_out_states = 16'd0;
        for (int i = 0; i < LINE_BYTES; i++) begin
            case (r_kind)
                K_FETCH: begin
                    n_out_data[8*i +: 8] = (4'(i) < n_cnt) ? r_rbytes[i] : 8'd0;
                end
                K_FILL: begin
                    if (r_states[2*i +: 2] == ST_UPDATED) begin
                        n_out_data[8*i +: 8] = r_data[8*i +: 8];
                        n_out_states[2*i +: 2] = ST_UPDATED;
                    end else begin
                        n_out_data[8*i +: 8] = r_rbytes[i];
                        n_out_states[2*i +: 2] = ST_VALID;
                    end
                end
                K_FLUSH: begin
                    n_out_data[8*i +: 8] = r_data[8*i +: 8];
                    n_out_states[2*i +: 2] = r_states[2*i +: 2];
                end
                K_MOVE: begin
                    n_out_data[8*i +: 8] = r_rbytes[i];
                    n_out_states[2*i +: 2] = ST_VALID;
                end
                default: begin
                    n_out_data[8*i +: 8] = 8'd0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.pad <= 5'd0;
            r_out.done_kind <= r_kind;
            r_out.read_data <= n_out_data;
            r_out.new_states <= n_out_states;
        end
    end

    assign o_item = r_out;
    assign o_out_valid = r_out_valid;

    `FLMLE_ASSERT_NOW(a_access_needs_request, i_clk, i_rst_n, i_cmd.wr_en || i_cmd.rd_en, r_kind != K_IDLE)
    `FLMLE_ASSERT_NEXT(a_load_retires, i_clk, i_rst_n, i_cmd.load_out, r_out_valid && (r_kind == K_IDLE))
    `FLMLE_ASSERT_NOW(a_idle_no_ticks, i_clk, i_rst_n, r_kind == K_IDLE, r_tick == 4'd0)

endmodule

/* hw/rtl/fixed_latency_memory_line_engine_unit.sv */
// Fixed-latency byte memory engine for an 8-byte-line cache; uses flmle_ctrl and flmle_dp.
// A request item or a tick that does not complete is taken with no memory pass. A completing
// tick runs over the single-port byte memory, one byte per cycle: store and flush write, fetch
// and fill read, move writes then reads; the next item is taken once the result is loaded.
// Reset is synchronous and active low; memory valid bits clear at once, so the memory reads
// as zeros right after reset with no clearing pass.
module fixed_latency_memory_line_engine_unit #(
    parameter int MEM_BYTES = 256
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // func, byte_address, byte_count, line_index, old_line_index, line_data, byte_states
    input  logic [flmle_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // done_kind, read_data, new_states
    output logic [flmle_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [2:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import flmle_pkg::*;

    logic [3:0] r_latency;
    t_cmd       cmd;
    t_status    status;
    t_in_item   item;
    t_out_item  out_item;

    assign pready = 1'b1;

    // Only one register; paddr[2] set addresses past it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latency <= 4'd5;
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            r_latency <= pwdata[3:0];
        end
    end

    assign prdata = paddr[2] ? 32'd0 : {28'd0, r_latency};

    assign item = t_in_item'(s_axis_tdata);
    assign m_axis_tdata = OUT_TDATA_W'(out_item);

    flmle_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    flmle_dp #(
        .MEM_BYTES (MEM_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item),
        .i_latency   (r_latency),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_item      (out_item),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready)
    );

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for fixed_latency_memory_line_engine_unit (request/tick stream in,
// completions out, latency over APB). Needs flmle_pkg and the RTL; reads no files.
module testbench;
    import flmle_pkg::*;

    localparam logic [2:0] REG_LATENCY = 3'd0;
    localparam logic [2:0] K_SPARE6    = 3'd6;
    localparam logic [2:0] K_SPARE7    = 3'd7;
    localparam int         SETTLE_CYCLES = 40;

    typedef struct packed {
        bit        set_on;
        logic [3:0] lat_val;
        t_in_item  item;
        bit        fixed_on;
        t_out_item fixed_res;
    } t_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [2:0]             paddr = '0;
    logic [31:0]            pwdata = '0;
    logic [31:0]            prdata;
    logic                   pready;

    fixed_latency_memory_line_engine_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #10 i_clk = ~i_clk;

    // Shadow copy of the engine: byte memory, latency register and the pending request.
    logic [7:0]  memory_image [256];
    logic [3:0]  cfg_latency;
    logic [2:0]  pend_kind;
    logic [3:0]  tick_cnt;
    logic [7:0]  pend_addr;
    logic [4:0]  pend_old;
    logic [3:0]  pend_cnt;
    logic [63:0] pend_data;
    logic [15:0] pend_states;

    t_out_item completion_q [$];
    t_row      script [$];

    int  n_errors = 0;
    int  n_checked = 0;
    int  n_accepted = 0;
    int  n_useful = 0;
    int  n_lat_writes = 0;
    bit  quiet_mode = 1'b0;
    bit  hold_off_req = 1'b0;

    function automatic bit predict_completion(input t_in_item item, output t_out_item res);
        int         lat;
        int         n;
        logic [7:0] obase;
        logic [1:0] st;
        res = '0;
        if (item.func >= K_FETCH && item.func <= K_MOVE) begin
            pend_kind = item.func;
            if (item.func == K_FETCH || item.func == K_STORE)
                pend_addr = item.byte_address;
            else
                pend_addr = {item.line_index, 3'b000};
            pend_cnt    = item.byte_count;
            pend_old    = item.old_line_index;
            pend_data   = item.line_data;
            pend_states = item.byte_states;
            return 1'b0;
        end
        if (item.func != K_TICK || pend_kind == K_IDLE)
            return 1'b0;
        lat = (cfg_latency == 4'd0) ? 1 : int'(cfg_latency);
        if (int'(tick_cnt) + 1 < lat) begin
            tick_cnt = tick_cnt + 4'd1;
            return 1'b0;
        end
        case (pend_kind)
            K_FETCH: begin
                n = (pend_cnt > 4'd8) ? 8 : int'(pend_cnt);
                for (int i = 0; i < n; i++)
                    res.read_data[8*i +: 8] = memory_image[8'(pend_addr + i)];
            end
            K_STORE: begin
                memory_image[pend_addr] = pend_data[7:0];
            end
            K_FILL: begin
                for (int i = 0; i < LINE_BYTES; i++) begin
                    st = pend_states[2*i +: 2];
                    if (st == ST_UPDATED) begin
                        res.read_data[8*i +: 8]  = pend_data[8*i +: 8];
                        res.new_states[2*i +: 2] = ST_UPDATED;
                    end else begin
                        res.read_data[8*i +: 8]  = memory_image[8'(pend_addr + i)];
                        res.new_states[2*i +: 2] = ST_VALID;
                    end
                end
            end
            K_FLUSH: begin
                for (int i = 0; i < LINE_BYTES; i++)
                    if (pend_states[2*i +: 2] == ST_UPDATED)
                        memory_image[8'(pend_addr + i)] = pend_data[8*i +: 8];
                res.read_data  = pend_data;
                res.new_states = pend_states;
            end
            default: begin
                // Write-back of the victim line goes first, so a move onto itself reads it back.
                obase = {pend_old, 3'b000};
                for (int i = 0; i < LINE_BYTES; i++)
                    if (pend_states[2*i +: 2] != ST_INVALID)
                        memory_image[8'(obase + i)] = pend_data[8*i +: 8];
                for (int i = 0; i < LINE_BYTES; i++) begin
                    res.read_data[8*i +: 8]  = memory_image[8'(pend_addr + i)];
                    res.new_states[2*i +: 2] = ST_VALID;
                end
            end
        endcase
        res.done_kind = pend_kind;
        pend_kind = K_IDLE;
        tick_cnt = '0;
        return 1'b1;
    endfunction

    function automatic t_in_item mk_item(input logic [2:0] f, input logic [7:0] addr,
                                         input logic [3:0] cnt, input logic [4:0] line,
                                         input logic [4:0] old, input logic [63:0] data,
                                         input logic [15:0] states);
        t_in_item item;
        item = '0;
        item.func           = f;
        item.byte_address   = addr;
        item.byte_count     = cnt;
        item.line_index     = line;
        item.old_line_index = old;
        item.line_data      = data;
        item.byte_states    = states;
        return item;
    endfunction

    function automatic t_out_item mk_res(input logic [2:0] kind, input logic [63:0] data,
                                         input logic [15:0] states);
        t_out_item res;
        res = '0;
        res.done_kind  = kind;
        res.read_data  = data;
        res.new_states = states;
        return res;
    endfunction

    // Half the addresses and lines land in the low corner of memory so reads hit written data.
    function automatic t_in_item make_random(input logic [2:0] f);
        t_in_item item;
        item = '0;
        item.func           = f;
        item.byte_address   = $urandom_range(1) ? 8'($urandom) : 8'($urandom_range(0, 31));
        item.byte_count     = ($urandom_range(3) == 0) ? 4'($urandom) : 4'($urandom_range(1, 8));
        item.line_index     = $urandom_range(1) ? 5'($urandom) : 5'($urandom_range(0, 3));
        item.old_line_index = $urandom_range(1) ? 5'($urandom) : 5'($urandom_range(0, 3));
        item.line_data      = {$urandom, $urandom};
        item.byte_states    = 16'($urandom);
        return item;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (quiet_mode || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void add_row(input bit set_on, input logic [3:0] lat_val,
                                    input t_in_item item, input bit fixed_on,
                                    input t_out_item fixed_res);
        t_row r;
        r.set_on    = set_on;
        r.lat_val   = lat_val;
        r.item      = item;
        r.fixed_on  = fixed_on;
        r.fixed_res = fixed_res;
        script.push_back(r);
    endfunction

    task automatic send_item(input t_in_item item, input bit fixed_on,
                             input t_out_item fixed_res);
        int        gap;
        t_out_item res;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= item;
        do @(posedge i_clk); while (!s_axis_tready);
        n_accepted++;
        if ((item.func >= K_FETCH && item.func <= K_MOVE) ||
            (item.func == K_TICK && pend_kind != K_IDLE))
            n_useful++;
        if (predict_completion(item, res))
            completion_q.push_back(fixed_on ? fixed_res : res);
    endtask

    task automatic wait_quiet();
        s_axis_tvalid <= 1'b0;
        while (completion_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_latency(input logic [3:0] value);
        wait_quiet();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_LATENCY;
        pwdata  <= {28'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        cfg_latency = value;
        n_lat_writes++;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {28'd0, value}) begin
            $display("%0t: latency readback expected %h got %h", $time, {28'd0, value}, prdata);
            n_errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_completion(input t_out_item got);
        t_out_item want;
        if (completion_q.size() == 0) begin
            $display("%0t: unexpected result kind %0d data %h states %h", $time,
                     got.done_kind, got.read_data, got.new_states);
            n_errors++;
            return;
        end
        want = completion_q.pop_front();
        n_checked++;
        if (got.done_kind !== want.done_kind) begin
            $display("%0t: done_kind expected %0d got %0d", $time, want.done_kind, got.done_kind);
            n_errors++;
        end
        if (got.read_data !== want.read_data) begin
            $display("%0t: read_data expected %h got %h", $time, want.read_data, got.read_data);
            n_errors++;
        end
        if (got.new_states !== want.new_states) begin
            $display("%0t: new_states expected %h got %h", $time, want.new_states,
                     got.new_states);
            n_errors++;
        end
    endtask

    initial begin : result_sink
        int stall_left;
        int hold_left;
        int r;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready)
                check_completion(m_axis_tdata);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (quiet_mode) begin
                m_axis_tready <= 1'b1;
            end else begin
                r = $urandom_range(99);
                if (r < 60) begin
                    m_axis_tready <= 1'b1;
                end else if (r < 92) begin
                    stall_left = $urandom_range(0, 2);
                    m_axis_tready <= 1'b0;
                end else begin
                    stall_left = $urandom_range(10, 40);
                    m_axis_tready <= 1'b0;
                end
            end
        end
    end

    initial begin : watchdog
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin : stimulus
        t_in_item  tick;
        t_in_item  req;
        t_out_item none;
        int        lat;
        int        goal;
        int        eff;
        int        nticks;
        int        r;

        foreach (memory_image[i])
            memory_image[i] = 8'h00;
        cfg_latency = 4'd5;
        pend_kind   = K_IDLE;
        tick_cnt    = '0;
        pend_addr   = '0;
        pend_old    = '0;
        pend_cnt    = 4'd1;
        pend_data   = '0;
        pend_states = '0;
        tick = mk_item(K_TICK, 8'h00, 4'd0, 5'd0, 5'd0, 64'd0, 16'd0);
        none = '0;

        // Memory is all zero after reset, so the first reads come back empty.
        add_row(1, 4'd1, mk_item(K_FETCH, 8'h00, 4'd8, 5'd0, 5'd0, 64'd0, 16'd0), 0, none);
        add_row(0, 4'd0, tick, 1, mk_res(K_FETCH, 64'd0, 16'd0));
        add_row(0, 4'd0, mk_item(K_STORE, 8'hFF, 4'd1, 5'd0, 5'd0, 64'hA5, 16'd0), 0, none);
        add_row(0, 4'd0, tick, 1, mk_res(K_STORE, 64'd0, 16'd0));
        // A fetch near the top of memory wraps back to address zero.
        add_row(0, 4'd0, mk_item(K_FETCH, 8'hFE, 4'd8, 5'd0, 5'd0, 64'd0, 16'd0), 0, none);
        add_row(0, 4'd0, tick, 1, mk_res(K_FETCH, 64'hA500, 16'd0));
        add_row(0, 4'd0, mk_item(K_FETCH, 8'hFF, 4'd0, 5'd0, 5'd0, 64'd0, 16'd0), 0, none);
        add_row(0, 4'd0, tick, 1, mk_res(K_FETCH, 64'd0, 16'd0));
        // Counts above eight are clipped to a full line.
        add_row(0, 4'd0, mk_item(K_FETCH, 8'hFF, 4'd15, 5'd0, 5'd0, 64'd0, 16'd0), 0, none);
        add_row(0, 4'd0, tick, 1, mk_res(K_FETCH, 64'hA5, 16'd0));
        // Flush with every state code present, code three among them.
        add_row(0, 4'd0, mk_item(K_FLUSH, 8'h00, 4'd0, 5'd31, 5'd0, 64'h0123_4567_89AB_CDEF,
                                 16'hB48E), 0, none);
        add_row(0, 4'd0, tick, 1, mk_res(K_FLUSH, 64'h0123_4567_89AB_CDEF, 16'hB48E));
        add_row(0, 4'd0, mk_item(K_MOVE, 8'h00, 4'd0, 5'd1, 5'd1, 64'hFFFF_FFFF_FFFF_FFFF,
                                 16'hAAAA), 0, none);
        add_row(0, 4'd0, tick, 1, mk_res(K_MOVE, 64'hFFFF_FFFF_FFFF_FFFF, 16'h5555));
        // Spare function codes and a tick with nothing pending must all be ignored.
        add_row(0, 4'd0, mk_item(K_SPARE6, 8'hFF, 4'hF, 5'h1F, 5'h1F, 64'hFFFF_FFFF_FFFF_FFFF,
                                 16'hFFFF), 0, none);
        add_row(0, 4'd0, mk_item(K_SPARE7, 8'hFF, 4'hF, 5'h1F, 5'h1F, 64'hFFFF_FFFF_FFFF_FFFF,
                                 16'hFFFF), 0, none);
        add_row(0, 4'd0, tick, 0, none);
        // A new request replaces the pending store before it completes.
        add_row(0, 4'd0, mk_item(K_STORE, 8'h03, 4'd1, 5'd0, 5'd0, 64'h77, 16'd0), 0, none);
        add_row(0, 4'd0, mk_item(K_FETCH, 8'h08, 4'd2, 5'd0, 5'd0, 64'd0, 16'd0), 0, none);
        add_row(0, 4'd0, tick, 1, mk_res(K_FETCH, 64'hFFFF, 16'd0));
        // Latency lowered under a pending fill: the next tick completes it.
        add_row(1, 4'd15, mk_item(K_FILL, 8'h00, 4'd0, 5'd1, 5'd0, 64'd0, 16'd0), 0, none);
        add_row(0, 4'd0, tick, 0, none);
        add_row(0, 4'd0, tick, 0, none);
        add_row(1, 4'd2, tick, 1, mk_res(K_FILL, 64'hFFFF_FFFF_FFFF_FFFF, 16'h5555));
        // A latency setting of zero is treated like the smallest nonzero setting.
        add_row(1, 4'd0, mk_item(K_STORE, 8'h10, 4'd1, 5'd0, 5'd0, 64'h5A, 16'd0), 0, none);
        add_row(0, 4'd0, tick, 1, mk_res(K_STORE, 64'd0, 16'd0));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[i]) begin
            if (script[i].set_on)
                set_latency(script[i].lat_val);
            send_item(script[i].item, script[i].fixed_on, script[i].fixed_res);
        end

        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0:       lat = 1;
                1:       lat = 15;
                2:       lat = 0;
                3:       lat = 2;
                default: lat = $urandom_range(15);
            endcase
            set_latency(4'(lat));
            quiet_mode = (ph == 3);
            // The output side stops for a long while so the engine backs up into its input.
            if (ph == 0)
                hold_off_req = 1'b1;
            goal = n_useful + 100;
            while (n_useful < goal) begin
                if ($urandom_range(99) < 85) begin
                    req = make_random(3'($urandom_range(1, 5)));
                    send_item(req, 0, none);
                    eff = (cfg_latency == 4'd0) ? 1 : int'(cfg_latency);
                    r = $urandom_range(9);
                    if (r < 7)
                        nticks = eff;
                    else if (r < 9)
                        nticks = eff + $urandom_range(1, 3);
                    else
                        nticks = $urandom_range(0, eff - 1);
                    repeat (nticks) send_item(make_random(K_TICK), 0, none);
                end else begin
                    send_item(make_random(3'($urandom)), 0, none);
                end
            end
        end
        quiet_mode = 1'b0;
        wait_quiet();

        $display("Accepted %0d items (%0d requests or live ticks) across %0d latency writes.",
                 n_accepted, n_useful, n_lat_writes);
        $display("Compared %0d completions, %0d mismatches.", n_checked, n_errors);
        if (n_errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

/* fixed_latency_memory_line_engine_unit.f */
+incdir+hw/rtl
hw/rtl/flmle_pkg.sv
hw/rtl/flmle_ctrl.sv
hw/rtl/flmle_dp.sv
hw/rtl/fixed_latency_memory_line_engine_unit.sv
bench/testbench.sv
